[src/xrg_pkg.sv]
// Package: shared types and constants for the xoshiro256++ range generator.
`timescale 1ns / 1ps
`default_nettype none
package xrg_pkg;

  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;

  localparam logic [1:0] OpReseed = 2'd0;
  localparam logic [1:0] OpRaw = 2'd1;
  localparam logic [1:0] OpRange = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StMixA,
    StMulA,
    StMulB,
    StMixC,
    StThresh,
    StDraw,
    StCheck,
    StMod,
    StDone
  } state_e;

  // Control from sequencer to the shared multiply / divide datapath.
  typedef struct packed {
    logic mul_start;
    logic div_start;
  } unit_ctl_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } unit_sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
    logic [127:0] w;
    w = {v, v} << amt;
    return w[127:64];
  endfunction

endpackage
`default_nettype wire

[src/xrg_if.sv]
// Interface: valid/ready channel carrying one item.
`timescale 1ns / 1ps
`default_nettype none
interface xrg_in_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [63:0] seed;
  logic signed [31:0] low_bound;
  logic signed [31:0] high_bound;
  modport source(output valid, op, seed, low_bound, high_bound, input ready);
  modport sink(input valid, op, seed, low_bound, high_bound, output ready);
endinterface

interface xrg_out_if;
  logic valid;
  logic ready;
  logic [63:0] raw_value;
  logic signed [31:0] int_value;
  logic bad_range;
  modport source(output valid, raw_value, int_value, bad_range, input ready);
  modport sink(input valid, raw_value, int_value, bad_range, output ready);
endinterface
`default_nettype wire

[src/xoshiro256pp_range_generator_core.sv]
// Top level: xoshiro256++ generator with reseed and bounded draw.
// Sequence: a raw draw steps the state and goes to done; reseed runs 8 multiplies,
// two per state word; bounded draw runs a 64-step threshold remainder, then draws
// and, once a draw is accepted, a 64-step remainder of it, redrawing on each rare
// rejected draw; unused op and inverted range go straight to done.
// Throughput: one item at a time; ready only when idle with no result pending.
// Reset: asynchronous, active low; runs a reseed with zero, and the first item is
// accepted only once that reseed is done.
`timescale 1ns / 1ps
`default_nettype none
module xoshiro256pp_range_generator_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xrg_in_if.sink      in_if,
  xrg_out_if.source   out_if
);
  xrg_pkg::state_e state_q, state_d;
  xrg_pkg::unit_ctl_t ctl;
  xrg_pkg::unit_sts_t sts;

  logic [63:0] w0_q, w1_q, w2_q, w3_q;
  logic [63:0] v_q, v_d;          // mix accumulator
  logic [1:0]  word_q;            // word being reseeded
  logic [31:0] lo_q;
  logic [32:0] span_q, thresh_q;
  logic [63:0] draw_q;
  logic        out_valid_q;
  logic [63:0] raw_q;
  logic [31:0] int_q;
  logic        bad_q;
  logic        busy_rs_q;         // reseed after reset in progress

  logic [63:0] mul_a, mul_b, mul_p, div_num;
  logic [32:0] div_den;
  logic [32:0] div_rem;
  logic [63:0] xo_res;
  logic [32:0] span_c;
  logic        accept;

  // Sequencer flags
  logic do_draw, load_word, latch_thresh, load_out;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == xrg_pkg::StIdle) && !out_valid_q && !busy_rs_q;
  assign span_c = {in_if.high_bound[31], in_if.high_bound}
                - {in_if.low_bound[31], in_if.low_bound} + 33'd1;

  assign xo_res = xrg_pkg::rotl64(w0_q + w3_q, 23) + w0_q;

  xrg_mul u_mul (
    .clk_i, .rst_ni, .start_i(ctl.mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(sts.mul_done), .p_o(mul_p)
  );

  xrg_div u_div (
    .clk_i, .rst_ni, .start_i(ctl.div_start), .num_i(div_num), .den_i(div_den),
    .done_o(sts.div_done), .rem_o(div_rem)
  );

  // Multiplier operands: first or second mix stage, latched at start.
  always_comb begin
    mul_a = (v_q ^ (v_q >> 30));
    mul_b = xrg_pkg::MixMul1;
    if (state_q == xrg_pkg::StMixC) begin
      mul_a = v_q ^ (v_q >> 27);
      mul_b = xrg_pkg::MixMul2;
    end
  end

  // Threshold numerator is 2^64 - span, started at accept; later the accepted draw.
  assign div_num = (state_q == xrg_pkg::StIdle) ? (64'd0 - {31'd0, span_c}) : draw_q;
  assign div_den = (state_q == xrg_pkg::StIdle) ? span_c : span_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      xrg_pkg::StIdle: begin
        if (busy_rs_q) state_d = xrg_pkg::StMixA;
        else if (accept) begin
          if (in_if.op == xrg_pkg::OpReseed) state_d = xrg_pkg::StMixA;
          else if (in_if.op == xrg_pkg::OpRange &&
                   $signed(in_if.high_bound) >= $signed(in_if.low_bound))
            state_d = xrg_pkg::StThresh;
          else state_d = xrg_pkg::StDone;
        end
      end
      xrg_pkg::StMixA: state_d = xrg_pkg::StMulA;
      xrg_pkg::StMulA: if (sts.mul_done) state_d = xrg_pkg::StMixC;
      xrg_pkg::StMixC: state_d = xrg_pkg::StMulB;
      xrg_pkg::StMulB: begin
        if (sts.mul_done) state_d = (word_q == 2'd3) ? xrg_pkg::StDone : xrg_pkg::StMixA;
      end
      xrg_pkg::StThresh: if (sts.div_done) state_d = xrg_pkg::StDraw;
      xrg_pkg::StDraw: state_d = xrg_pkg::StCheck;
      xrg_pkg::StCheck: state_d = ({31'd0, thresh_q} > draw_q) ? xrg_pkg::StDraw
                                                               : xrg_pkg::StMod;
      xrg_pkg::StMod: if (sts.div_done) state_d = xrg_pkg::StDone;
      xrg_pkg::StDone: state_d = xrg_pkg::StIdle;
      default: state_d = xrg_pkg::StIdle;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ctl.mul_start = 1'b0;
    ctl.div_start = 1'b0;
    do_draw = 1'b0;
    load_word = 1'b0;
    latch_thresh = 1'b0;
    load_out = 1'b0;
    case (state_q)
      xrg_pkg::StIdle: begin
        ctl.div_start = accept && in_if.op == xrg_pkg::OpRange;
        do_draw = accept && in_if.op == xrg_pkg::OpRaw;
      end
      xrg_pkg::StMixA: ctl.mul_start = 1'b1;
      xrg_pkg::StMixC: ctl.mul_start = 1'b1;
      xrg_pkg::StMulB: load_word = sts.mul_done;
      xrg_pkg::StThresh: latch_thresh = sts.div_done;
      xrg_pkg::StDraw: do_draw = 1'b1;
      xrg_pkg::StCheck: ctl.div_start = ({31'd0, thresh_q} <= draw_q);
      xrg_pkg::StDone: load_out = 1'b1;
      default: ;
    endcase
  end

  // Mix accumulator: add golden, then fold in multiplier products.
  always_comb begin
    v_d = v_q;
    if (state_q == xrg_pkg::StIdle) v_d = in_if.seed + xrg_pkg::Golden;
    else if (state_q == xrg_pkg::StMulA && sts.mul_done) v_d = mul_p;
    else if (state_q == xrg_pkg::StMulB && sts.mul_done) begin
      v_d = mul_p ^ (mul_p >> 31);
      v_d = v_d + xrg_pkg::Golden;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xrg_pkg::StIdle;
      busy_rs_q <= 1'b1;
      out_valid_q <= 1'b0;
      word_q <= '0;
      v_q <= xrg_pkg::Golden;
    end else begin
      state_q <= state_d;
      if (busy_rs_q && state_q == xrg_pkg::StIdle) v_q <= v_q;
      else v_q <= v_d;
      if (state_q == xrg_pkg::StDone) busy_rs_q <= 1'b0;
      if (accept) begin
        word_q <= '0;
      end
      if (load_word) word_q <= word_q + 2'd1;
      if (load_out && !busy_rs_q) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q <= in_if.low_bound;
      span_q <= span_c;
      raw_q <= (in_if.op == xrg_pkg::OpRaw) ? xo_res : 64'd0;
      if (in_if.op == xrg_pkg::OpRange &&
          $signed(in_if.high_bound) < $signed(in_if.low_bound)) begin
        int_q <= in_if.low_bound;
        bad_q <= 1'b1;
      end else begin
        int_q <= '0;
        bad_q <= 1'b0;
      end
    end
    if (latch_thresh) thresh_q <= div_rem;
    if (load_word) begin
      case (word_q)
        2'd0: w0_q <= mul_p ^ (mul_p >> 31);
        2'd1: w1_q <= mul_p ^ (mul_p >> 31);
        2'd2: w2_q <= mul_p ^ (mul_p >> 31);
        default: w3_q <= mul_p ^ (mul_p >> 31);
      endcase
    end
    if (do_draw) begin
      draw_q <= xo_res;
      w2_q <= w2_q ^ w0_q ^ (w1_q << 17);
      w3_q <= xrg_pkg::rotl64(w3_q ^ w1_q, 45);
      w1_q <= w1_q ^ w2_q ^ w0_q;
      w0_q <= w0_q ^ w3_q ^ w1_q;
    end
    if (state_q == xrg_pkg::StMod && sts.div_done) int_q <= div_rem[31:0] + lo_q;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.raw_value = raw_q;
  assign out_if.int_value = int_q;
  assign out_if.bad_range = bad_q;

`ifndef NO_ASSERTIONS
  // No new item while a result is pending.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_if.ready) else $error("accepted item with result pending");
  // No result flags a bad range and carries a raw value at once.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.bad_range && out_if.raw_value != 64'd0))
    else $error("bad_range with raw value");
  // Multiplier only starts in mix states.
  a_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.mul_start |-> (state_q == xrg_pkg::StMixA || state_q == xrg_pkg::StMixC))
    else $error("stray multiply");
`endif
endmodule
`default_nettype wire

[src/xrg_mul.sv]
// Multiplier: 64x64 low product from three 32x32 partial products, one per step.
`timescale 1ns / 1ps
`default_nettype none
module xrg_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      p_o
);
  logic [2:0]  step_q, step_d;
  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [31:0] ma, mb;
  logic [63:0] pp;

  always_comb begin
    case (step_q[1:0])
      2'd0: begin ma = a_q[31:0]; mb = b_q[31:0]; end
      2'd1: begin ma = a_q[63:32]; mb = b_q[31:0]; end
      2'd2: begin ma = a_q[31:0]; mb = b_q[63:32]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign pp = {32'd0, ma} * {32'd0, mb};

  always_comb begin
    acc_d = acc_q;
    step_d = step_q;
    if (start_i) begin
      acc_d = '0;
      step_d = 3'd4;
    end else if (step_q[2]) begin
      case (step_q[1:0])
        2'd0: acc_d = pp;
        2'd1: acc_d = acc_q + {pp[31:0], 32'd0};
        2'd2: acc_d = acc_q + {pp[31:0], 32'd0};
        default: acc_d = acc_q;
      endcase
      step_d = (step_q[1:0] == 2'd3) ? 3'd0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign done_o = (step_q == 3'd7);
  assign p_o = acc_q;
endmodule
`default_nettype wire

[src/xrg_div.sv]
// Divider: restoring 64-by-33-bit remainder, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module xrg_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [32:0]      rem_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] num_q, num_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q;
  logic [33:0] shifted, diff;

  assign shifted = {rem_q[32:0], num_q[63]};
  assign diff = shifted - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = 7'd64;
      num_d = num_i;
      rem_d = '0;
    end else if (cnt_q != 7'd0) begin
      num_d = {num_q[62:0], 1'b0};
      rem_d = diff[33] ? shifted : diff;
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = (cnt_q == 7'd1);
  assign rem_o = rem_d[32:0];
endmodule
`default_nettype wire

[sim/xoshiro256pp_range_generator_core_tb.sv]
// Testbench: directed table plus random requests against a behavioral xoshiro256++ predictor.
`timescale 1ns / 1ps
module xoshiro256pp_range_generator_core_tb;

  localparam int StallLimit = 20000;
  localparam int NumRandom = 1330;

  typedef struct packed {
    logic [1:0]         op;
    logic [63:0]        seed;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } gen_req_t;

  typedef struct packed {
    logic [63:0]        raw;
    logic signed [31:0] ival;
    logic               bad;
  } gen_res_t;

  // directed row: request, and a typed-in result where one is obvious
  typedef struct {
    gen_req_t req;
    logic     fixed;
    gen_res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  xrg_in_if  in_ch ();
  xrg_out_if out_ch ();

  xoshiro256pp_range_generator_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  logic [63:0] st_words [4];
  gen_res_t    pending_q [$];
  gen_req_t    stim_q [$];
  logic        fixed_q [$];
  gen_res_t    fixedres_q [$];
  int          mismatches = 0;
  int          n_sent = 0;
  int          n_recv = 0;
  int          n_reject = 0;
  int          idle_cycles = 0;
  bit          timed_out = 0;
  bit          stim_done = 0;
  bit          hold_long = 0;

  function automatic logic [63:0] rol(logic [63:0] v, int amt);
    return (v << amt) | (v >> (64 - amt));
  endfunction

  function automatic logic [63:0] splitmix(logic [63:0] v);
    v = v + 64'h9e3779b97f4a7c15;
    v = (v ^ (v >> 30)) * 64'hbf58476d1ce4e5b9;
    v = (v ^ (v >> 27)) * 64'h94d049bb133111eb;
    return v ^ (v >> 31);
  endfunction

  task automatic load_seed(logic [63:0] s);
    st_words[0] = splitmix(s);
    for (int k = 1; k < 4; k++) st_words[k] = splitmix(st_words[k-1]);
  endtask

  task automatic next_draw(output logic [63:0] r);
    logic [63:0] sh;
    r = rol(st_words[0] + st_words[3], 23) + st_words[0];
    sh = st_words[1] << 17;
    st_words[2] ^= st_words[0];
    st_words[3] ^= st_words[1];
    st_words[1] ^= st_words[2];
    st_words[0] ^= st_words[3];
    st_words[2] ^= sh;
    st_words[3] = rol(st_words[3], 45);
  endtask

  task automatic predict_gen(gen_req_t q, output gen_res_t e);
    logic [63:0] r, span, thr;
    e = '0;
    case (q.op)
      xrg_pkg::OpReseed: load_seed(q.seed);
      xrg_pkg::OpRaw: begin
        next_draw(r);
        e.raw = r;
      end
      xrg_pkg::OpRange: begin
        if ($signed(q.hi) < $signed(q.lo)) begin
          e.ival = q.lo;
          e.bad = 1'b1;
        end else begin
          span = 64'($signed(q.hi)) - 64'($signed(q.lo)) + 64'd1;
          thr = (64'd0 - span) % span;
          next_draw(r);
          while (r < thr) begin
            n_reject++;
            next_draw(r);
          end
          e.ival = 32'(r % span) + q.lo;
        end
      end
      default: ;
    endcase
  endtask

  function automatic gen_req_t mk(logic [1:0] op, logic [63:0] s, int lo, int hi);
    gen_req_t q;
    q.op = op; q.seed = s; q.lo = lo; q.hi = hi;
    return q;
  endfunction

  function automatic gen_req_t rand_req();
    gen_req_t q;
    int unsigned pick;
    q.seed = {$urandom, $urandom};
    q.lo = $urandom;
    q.hi = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 6) q.op = xrg_pkg::OpReseed;
    else if (pick < 45) q.op = xrg_pkg::OpRaw;
    else if (pick < 97) q.op = xrg_pkg::OpRange;
    else q.op = xrg_pkg::OpUnused;
    if (q.op == xrg_pkg::OpRange) begin
      pick = $urandom_range(0, 9);
      // half small spans, some wide, some inverted
      if (pick < 5) q.hi = q.lo + 32'($urandom_range(0, 1000));
      else if (pick < 7 && q.hi < q.lo) {q.lo, q.hi} = {q.hi, q.lo};
      else if (pick == 7) q.hi = q.lo + 32'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
    end
    if (q.hi < q.lo && q.op == xrg_pkg::OpRange && pick == 8) q.hi = q.lo;
    return q;
  endfunction

  // stimulus build
  initial begin
    dir_row_t tbl [$];
    dir_row_t row;
    gen_res_t z;
    z = '0;
    row.fixed = 1; row.res = z;
    row.req = mk(xrg_pkg::OpReseed, 64'd0, 0, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpUnused, '1, -1, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpReseed, '1, 0, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 32'h7fffffff, 32'h80000000);
    row.res = '{raw: 0, ival: 32'h7fffffff, bad: 1}; tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 5, 4);
    row.res = '{raw: 0, ival: 5, bad: 1}; tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 7, 7);
    row.res = '{raw: 0, ival: 7, bad: 0}; tbl.push_back(row);
    row.fixed = 0;
    row.req = mk(xrg_pkg::OpRaw, 0, 0, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRaw, '1, '1, '1); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 32'h80000000, 32'h7fffffff); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 32'h80000000, 32'h80000000); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 32'h7fffffff, 32'h7fffffff); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 0, 2); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, -3, 3); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 0, 32'h7fffffff); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 32'h80000000, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpReseed, 64'h5555_5555_aaaa_aaaa, 0, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRaw, 0, 0, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRange, 0, 1, 32'h60000001); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpUnused, 0, 0, 0); tbl.push_back(row);
    row.req = mk(xrg_pkg::OpRaw, 0, 0, 0); tbl.push_back(row);
    foreach (tbl[k]) begin
      stim_q.push_back(tbl[k].req);
      fixed_q.push_back(tbl[k].fixed);
      fixedres_q.push_back(tbl[k].res);
    end
    for (int k = 0; k < NumRandom; k++) begin
      stim_q.push_back(rand_req());
      fixed_q.push_back(0);
      fixedres_q.push_back('0);
    end
  end

  // sender: bursts with gaps, driven on the falling edge
  initial begin
    int burst;
    int idx;
    gen_res_t e;
    in_ch.valid = 0; in_ch.op = '0; in_ch.seed = '0;
    in_ch.low_bound = '0; in_ch.high_bound = '0;
    load_seed(64'd0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < stim_q.size()) begin
        in_ch.valid = 1;
        in_ch.op = stim_q[idx].op;
        in_ch.seed = stim_q[idx].seed;
        in_ch.low_bound = stim_q[idx].lo;
        in_ch.high_bound = stim_q[idx].hi;
        do @(posedge clk_i); while (!in_ch.ready);
        predict_gen(stim_q[idx], e);
        if (fixed_q[idx]) e = fixedres_q[idx];
        pending_q.push_back(e);
        n_sent++; idx++; burst--;
        @(negedge clk_i);
      end
      in_ch.valid = 0;
      repeat ($urandom_range(0, 150)) @(negedge clk_i);
    end
    in_ch.valid = 0;
    stim_done = 1;
  end

  // receiver stall pattern, with one long hold-off after 40 results
  initial begin
    int mode;
    out_ch.ready = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (n_recv == 40 && !hold_long) begin
        hold_long = 1;
        out_ch.ready = 0;
        repeat (3000) @(negedge clk_i);
      end
      mode = (n_recv / 100) % 3;
      if (mode == 0) out_ch.ready = 1;
      else if (mode == 1) out_ch.ready = ($urandom_range(0, 3) != 0);
      else out_ch.ready = ($urandom_range(0, 9) < 2);
    end
  end

  // result check at the rising edge
  always @(posedge clk_i) begin
    gen_res_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{raw: out_ch.raw_value, ival: out_ch.int_value, bad: out_ch.bad_range};
      n_recv++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: raw %h int %0d bad %b",
                                       got.raw, got.ival, got.bad);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch item %0d: raw exp %h got %h int exp %0d got %0d",
                      " bad exp %b got %b"},
                     n_recv, want.raw, got.raw, want.ival, got.ival, want.bad, got.bad);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) timed_out <= 1;
  end

  initial begin
    wait ((stim_done && pending_q.size() == 0) || timed_out);
    if (!timed_out) repeat (300) @(posedge clk_i);
    if (!timed_out && pending_q.size() != 0) wait (pending_q.size() == 0 || timed_out);
    $display("run: %0d items in, %0d results out, %0d rejected draws, %0d mismatches",
             n_sent, n_recv, n_reject, mismatches);
    $display("covered reseeds, raw draws, bounded draws incl. inverted and full ranges, op 3");
    if (timed_out) begin
      $display("FAIL xoshiro256pp_range_generator_core");
    end else if (mismatches == 0 && pending_q.size() == 0) begin
      $display("PASS xoshiro256pp_range_generator_core");
    end else begin
      $display("FAIL xoshiro256pp_range_generator_core");
    end
    $finish;
  end

endmodule

[filelist.f]
src/xrg_pkg.sv
src/xrg_if.sv
src/xrg_mul.sv
src/xrg_div.sv
src/xoshiro256pp_range_generator_core.sv
sim/xoshiro256pp_range_generator_core_tb.sv
